// ----- rtl/core/smcs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smcs_pkg
// Shared types and constants for the sparse matrix coordinate store.
// ----------------------------------------------------------------------------
package smcs_pkg;

    localparam int IDX_W  = 6;   // row / column index
    localparam int VAL_W  = 32;  // element value
    localparam int DIM_W  = 7;   // dimension register
    localparam int POS_W  = 13;  // row-major load position
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR_DIAG = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_ROW  = 3'd4;

    // Result status
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_DONE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    // One stored nonzero entry
    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } entry_t;

endpackage : smcs_pkg
`default_nettype wire

// ----- rtl/core/smcs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smcs_ram
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smcs_ram #(
    parameter int DEPTH = 256
) (
    input  wire                        aclk,
    input  wire                        wr_en,
    input  wire [$clog2(DEPTH)-1:0]    wr_addr,
    input  wire smcs_pkg::entry_t      wr_data,
    input  wire                        rd_en,
    input  wire [$clog2(DEPTH)-1:0]    rd_addr,
    output smcs_pkg::entry_t           rd_data
);
    import smcs_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : smcs_ram
`default_nettype wire

// ----- rtl/core/smcs_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smcs_div
// Restoring divider, one quotient bit per cycle: position / columns.
// ----------------------------------------------------------------------------
module smcs_div (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire [smcs_pkg::POS_W-1:0]    dividend,
    input  wire [smcs_pkg::DIM_W-1:0]    divisor,
    output logic                         done,
    output logic [smcs_pkg::POS_W-1:0]   quotient,
    output logic [smcs_pkg::DIM_W-1:0]   remainder
);
    import smcs_pkg::*;

    localparam int CNT_W = $clog2(POS_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [POS_W-1:0]     quo_reg;
    logic [DIM_W-1:0]     rem_reg;
    logic [DIM_W-1:0]     dsr_reg;

    logic [DIM_W:0]       trial;
    logic                 ge;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[POS_W-1]};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(POS_W);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= ge ? DIM_W'(trial - {1'b0, dsr_reg}) : trial[DIM_W-1:0];
                quo_reg <= {quo_reg[POS_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule : smcs_div
`default_nettype wire

// ----- rtl/core/sparse_matrix_coordinate_store_unit.sv -----
`default_nettype none
// Load runs the divider when the value is stored and skips it when the value is zero
// or dropped. Lookup and clear diagonal walk the list one entry per cycle through the
// single read port; read row repeats the lookup scan once per column. One word in at
// a time; a held output word stalls the sequencer until taken, then the next word is
// accepted. Reset (sync, aresetn low) empties the list, zeroes the load position,
// dimensions = 4.
// ----------------------------------------------------------------------------
// sparse_matrix_coordinate_store_unit
// Row-major list of nonzero matrix entries with clear, load, lookup, diagonal
// compaction and dense row read-back, under a small sequencer.
// ----------------------------------------------------------------------------
module sparse_matrix_coordinate_store_unit #(
    parameter int MAX_ENTRIES = 256,
    parameter int MAX_DIM     = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    // command [2:0], row [8:3], col [14:9], value [46:15], zero [47]
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,
    // data [31:0], status [33:32], zero [39:34]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    // configuration write channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire  [6:0]  cfg_data
);
    import smcs_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_DIV, S_SCAN, S_DIAG, S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [IDX_W-1:0]        row_reg, row_next;
    logic [IDX_W-1:0]        col_reg, col_next;
    logic [VAL_W-1:0]        val_reg, val_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CW-1:0]           scan_idx_reg, scan_idx_next;
    logic [CW-1:0]           wr_idx_reg, wr_idx_next;
    logic                    dv_reg, dv_next;
    logic [VAL_W-1:0]        res_data_reg, res_data_next;
    logic [STAT_W-1:0]       res_status_reg, res_status_next;
    logic                    res_last_reg, res_last_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0]        m_data_reg, m_data_next;
    logic [STAT_W-1:0]       m_status_reg, m_status_next;
    logic                    m_last_reg, m_last_next;
    logic [DIM_W-1:0]        num_rows_reg, num_rows_next;
    logic [DIM_W-1:0]        num_cols_reg, num_cols_next;

    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr;
    entry_t                  ram_wdata, ent;
    logic                    div_start, div_done;
    logic [POS_W-1:0]        div_quo;
    logic [DIM_W-1:0]        div_rem;

    logic [DIM_W-1:0]        rows_eff, cols_eff;
    logic [2*DIM_W-1:0]      total;
    logic                    row_gt, hit, diag, more;
    logic                    out_free, rd_last;

    // Clamp dimensions into 1..MAX_DIM
    always_comb begin
        rows_eff = num_rows_reg;
        if (num_rows_reg == '0) rows_eff = DIM_W'(1);
        else if (num_rows_reg > DIM_W'(MAX_DIM)) rows_eff = DIM_W'(MAX_DIM);
        cols_eff = num_cols_reg;
        if (num_cols_reg == '0) cols_eff = DIM_W'(1);
        else if (num_cols_reg > DIM_W'(MAX_DIM)) cols_eff = DIM_W'(MAX_DIM);
    end

    assign total = rows_eff * cols_eff;

    // Shared compare unit over the entry just read
    assign row_gt  = (ent.row > row_reg);
    assign hit     = (ent.row == row_reg) && (ent.col == col_reg);
    assign diag    = (ent.row == ent.col);
    assign more    = (scan_idx_reg < count_reg);
    assign rd_last = (cmd_reg != CMD_READ_ROW) ||
                     (DIM_W'({1'b0, col_reg} + 1'b1) == cols_eff);
    assign out_free = !m_tvalid_reg || m_tready;

    smcs_ram #(.DEPTH(MAX_ENTRIES)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (ent)
    );

    smcs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (pos_reg),
        .divisor   (cols_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        scan_idx_next   = scan_idx_reg;
        wr_idx_next     = wr_idx_reg;
        dv_next         = dv_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_data_next     = m_data_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;
        num_rows_next   = num_rows_reg;
        num_cols_next   = num_cols_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = ent;
        div_start       = 1'b0;

        // Drop the output word once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_valid) begin
            if (cfg_index == CFG_NUM_ROWS) num_rows_next = cfg_data;
            else                           num_cols_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next        = s_tdata[2:0];
                    row_next        = s_tdata[8:3];
                    col_next        = s_tdata[14:9];
                    val_next        = s_tdata[46:15];
                    scan_idx_next   = '0;
                    wr_idx_next     = '0;
                    dv_next         = 1'b0;
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    res_last_next   = 1'b1;
                    case (s_tdata[2:0])
                        CMD_CLEAR: begin
                            count_next = '0;
                            pos_next   = '0;
                            state_next = S_EMIT;
                        end
                        CMD_LOAD:       state_next = S_LOAD;
                        CMD_LOOKUP:     state_next = S_SCAN;
                        CMD_CLEAR_DIAG: state_next = S_DIAG;
                        CMD_READ_ROW: begin
                            col_next   = '0;
                            state_next = S_SCAN;
                        end
                        default:        state_next = S_EMIT;
                    endcase
                end
            end
            S_LOAD: begin
                if ({1'b0, pos_reg} >= total) begin
                    res_status_next = ST_DONE;
                    state_next      = S_EMIT;
                end else if (val_reg == '0) begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_EMIT;
                end else if (count_reg >= CW'(MAX_ENTRIES)) begin
                    res_status_next = ST_FULL;
                    pos_next        = pos_reg + 1'b1;
                    state_next      = S_EMIT;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                // Append the entry at its row-major coordinates
                if (div_done) begin
                    ram_we          = 1'b1;
                    ram_waddr       = count_reg[AW-1:0];
                    ram_wdata.row   = div_quo[IDX_W-1:0];
                    ram_wdata.col   = div_rem[IDX_W-1:0];
                    ram_wdata.value = val_reg;
                    count_next      = count_reg + 1'b1;
                    pos_next        = pos_reg + 1'b1;
                    state_next      = S_EMIT;
                end
            end
            S_SCAN: begin
                // Check the entry read last cycle, fetch the next one
                if (dv_reg && (hit || row_gt)) begin
                    res_data_next = hit ? ent.value : '0;
                    res_last_next = rd_last;
                    dv_next       = 1'b0;
                    state_next    = S_EMIT;
                end else if (more) begin
                    ram_re        = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                    dv_next       = 1'b1;
                end else begin
                    res_data_next = '0;
                    res_last_next = rd_last;
                    dv_next       = 1'b0;
                    state_next    = S_EMIT;
                end
            end
            S_DIAG: begin
                // Compact off-diagonal entries toward the front
                if (dv_reg && !diag) begin
                    ram_we      = 1'b1;
                    ram_waddr   = wr_idx_reg[AW-1:0];
                    ram_wdata   = ent;
                    wr_idx_next = wr_idx_reg + 1'b1;
                end
                if (more) begin
                    ram_re        = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                    dv_next       = 1'b1;
                end else begin
                    dv_next = 1'b0;
                    if (!dv_reg) begin
                        count_next = wr_idx_reg;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = res_data_reg;
                    m_status_next = res_status_reg;
                    m_last_next   = res_last_reg;
                    if (cmd_reg == CMD_READ_ROW && !res_last_reg) begin
                        col_next      = col_reg + 1'b1;
                        scan_idx_next = '0;
                        dv_next       = 1'b0;
                        state_next    = S_SCAN;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pos_reg      <= '0;
            dv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            num_rows_reg <= DIM_W'(4);
            num_cols_reg <= DIM_W'(4);
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            dv_reg       <= dv_next;
            m_tvalid_reg <= m_tvalid_next;
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
        end
        cmd_reg        <= cmd_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        val_reg        <= val_next;
        scan_idx_reg   <= scan_idx_next;
        wr_idx_reg     <= wr_idx_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        m_data_reg     <= m_data_next;
        m_status_reg   <= m_status_next;
        m_last_reg     <= m_last_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {6'b0, m_status_reg, m_data_reg};
    assign m_tlast   = m_last_reg;

endmodule : sparse_matrix_coordinate_store_unit
`default_nettype wire
